FILE: sv/cmd_pkg.sv
// Package for the chorus modulated delay: sizes, register indexes, memory port
// structs and the quarter-wave sine table. No dependencies.
package cmd_pkg;

   localparam int DELAY_DEPTH   = 2048;
   localparam int SAMPLE_BITS   = 24;
   localparam int SINE_ENTRIES  = 256;
   localparam int QUARTER       = SINE_ENTRIES / 4;

   localparam int ADDR_BITS     = $clog2(DELAY_DEPTH);
   localparam int FILL_BITS     = ADDR_BITS + 1;
   localparam int SINE_IDX_BITS = $clog2(SINE_ENTRIES);
   localparam int QUARTER_BITS  = SINE_IDX_BITS - 2;
   localparam int PHASE_BITS    = 32;
   localparam int TICK_BITS     = 18;
   localparam int SINE_BITS     = 17;
   localparam int TABLE_BITS    = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BASE_DELAY  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEPTH_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SWEEP_WIDTH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LFO_STEP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WET_MIX     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RATE_COUNT  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BYPASS      = 3'd6;

   typedef struct packed {
      logic                          en;
      logic [ADDR_BITS-1:0]          addr;
      logic signed [SAMPLE_BITS-1:0] data;
   } wr_req_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } rd_req_type;

   typedef logic [QUARTER:0][TABLE_BITS-1:0] sine_table_type;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

   // Fixed-point Taylor series of sin over the first quadrant, Q1.15 entries.
   function automatic sine_table_type build_sine_table();
      sine_table_type     tbl;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        q;
      logic signed [63:0] sum;
      for (int k = 0; k <= QUARTER; k++) begin
         x    = 64'(k) * HALF_PI_Q30 / QUARTER;
         x2   = (x * x) >> 30;
         term = x;
         sum  = signed'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         q = (unsigned'(sum) + 64'd16384) >> 15;
         if (q > 64'd32768) begin
            q = 64'd32768;
         end
         tbl[k] = q[TABLE_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

FILE: sv/cmd_if.sv
// Stream interfaces for the chorus request and response words.
// Depends on cmd_pkg for the sample width.
interface cmd_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cmd_pkg::SAMPLE_BITS-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface cmd_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cmd_pkg::SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

FILE: sv/cmd_lfo.sv
// Sine LFO: phase accumulator, tick counter and quarter-wave table lookup.
// Depends on cmd_pkg for widths and the sine table.
module cmd_lfo (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic [cmd_pkg::PHASE_BITS-1:0]         lfo_step,
   input  logic [cmd_pkg::TICK_BITS-1:0]          rate_count,
   output logic signed [cmd_pkg::SINE_BITS-1:0]   sine
);

   logic [cmd_pkg::PHASE_BITS-1:0]       phase_ff, phase_in;
   logic [cmd_pkg::TICK_BITS-1:0]        tick_ff, tick_in, tick_next;
   logic signed [cmd_pkg::SINE_BITS-1:0] sine_ff, sine_in;

   logic [cmd_pkg::SINE_IDX_BITS-1:0]    idx;
   logic [1:0]                           quad;
   logic [cmd_pkg::QUARTER_BITS-1:0]     r;
   logic [cmd_pkg::QUARTER_BITS:0]       tbl_idx;
   logic [cmd_pkg::TABLE_BITS-1:0]       mag;

   always_comb begin
      idx  = phase_ff[cmd_pkg::PHASE_BITS-1 -: cmd_pkg::SINE_IDX_BITS];
      quad = idx[cmd_pkg::SINE_IDX_BITS-1 -: 2];
      r    = idx[cmd_pkg::QUARTER_BITS-1:0];
      if (quad[0]) begin
         tbl_idx = (cmd_pkg::QUARTER_BITS+1)'(cmd_pkg::QUARTER) - {1'b0, r};
      end else begin
         tbl_idx = {1'b0, r};
      end
      mag = cmd_pkg::SINE_TABLE[tbl_idx];
      if (quad[1]) begin
         sine_in = -signed'({1'b0, mag});
      end else begin
         sine_in = signed'({1'b0, mag});
      end
   end

   always_comb begin
      tick_next = tick_ff + 1'b1;
      if (tick_next >= rate_count) begin
         tick_in  = '0;
         phase_in = '0;
      end else begin
         tick_in  = tick_next;
         phase_in = phase_ff + lfo_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         tick_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

FILE: sv/cmd_delay_line.sv
// Circular delay line memory with a fill count standing in for a cleared store.
// Depends on cmd_pkg for sizes and the port structs.
module cmd_delay_line (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmd_pkg::wr_req_type                  wr,
   input  cmd_pkg::rd_req_type                  rd,
   output logic signed [cmd_pkg::SAMPLE_BITS-1:0] rd_data
);

   logic signed [cmd_pkg::SAMPLE_BITS-1:0] mem [cmd_pkg::DELAY_DEPTH];
   logic signed [cmd_pkg::SAMPLE_BITS-1:0] rd_data_ff;
   logic                                   rd_hit_ff;
   logic [cmd_pkg::FILL_BITS-1:0]          fill_ff, fill_in, wr_end;

   // Writes run upward from address zero, so the written entries are always a prefix.
   always_comb begin
      wr_end  = {1'b0, wr.addr} + 1'b1;
      fill_in = fill_ff;
      if (wr.en && wr_end > fill_ff) begin
         fill_in = wr_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
         rd_hit_ff  <= {1'b0, rd.addr} < fill_ff;
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr.en && rd.en))
      else $error("delay line read and write in the same cycle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cmd_pkg::FILL_BITS'(cmd_pkg::DELAY_DEPTH))
      else $error("delay line fill count beyond depth");

   a_fill_covers: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> fill_ff > $past({1'b0, wr.addr}))
      else $error("written entry not covered by fill count");

endmodule

FILE: sv/chorus_modulated_delay.sv
// Chorus top level: one sample word in, one word out; a new word is taken only after the
// previous one has left the mix step (a bypassed word goes straight to the mix step).
// The single item in flight walks the ratio, scale, address, multiply and mix steps.
// The response register frees the datapath, so a word waits there while the next is taken.
// Reset loads register defaults and zeroes pointers; a fill count makes unwritten
// delay entries read as zero, so no clearing pass is needed. Uses cmd_pkg, cmd_if.
module chorus_modulated_delay (
   input  logic                                clock,
   input  logic                                reset,
   cmd_req_if.sink                             req_port,
   cmd_rsp_if.source                           rsp_port,
   input  logic                                csr_we,
   input  logic [cmd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cmd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int RATIO_BITS = 33;
   localparam int BD_BITS    = RATIO_BITS + 11;
   localparam int GAIN_BITS  = 32;
   localparam int PROD_BITS  = GAIN_BITS + 1 + cmd_pkg::SAMPLE_BITS;
   localparam int MIX_BITS   = PROD_BITS - 30;
   localparam int SUM_BITS   = MIX_BITS + 1;
   localparam int OFF_BITS   = BD_BITS - 30;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_RATIO = 6'b000010,
      ST_SCALE = 6'b000100,
      ST_ADDR  = 6'b001000,
      ST_MULT  = 6'b010000,
      ST_MIX   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [10:0]                          base_delay_ff;
   logic [15:0]                          depth_gain_ff;
   logic [15:0]                          sweep_width_ff;
   logic [cmd_pkg::PHASE_BITS-1:0]       lfo_step_ff;
   logic [15:0]                          wet_mix_ff;
   logic [cmd_pkg::TICK_BITS-1:0]        rate_count_ff;
   logic                                 bypass_ff;

   logic [cmd_pkg::ADDR_BITS-1:0]        write_pos_ff, write_pos_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [cmd_pkg::SAMPLE_BITS-1:0] rsp_data_ff;

   logic signed [cmd_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic                                 item_bypass_ff;
   logic [cmd_pkg::ADDR_BITS-1:0]        item_wp_ff;
   logic signed [RATIO_BITS-1:0]         ratio_ff;
   logic [GAIN_BITS-1:0]                 gain_ff;
   logic signed [BD_BITS-1:0]            bd_ff;
   logic signed [PROD_BITS-1:0]          prod_ff;

   logic                                 accept, advance, out_free;
   logic signed [cmd_pkg::SINE_BITS-1:0] sine;
   logic signed [cmd_pkg::SAMPLE_BITS-1:0] fb;
   cmd_pkg::wr_req_type                  wr;
   cmd_pkg::rd_req_type                  rd;

   logic [OFF_BITS-1:0]                  off_full;
   logic [cmd_pkg::ADDR_BITS-1:0]        off;
   logic [cmd_pkg::ADDR_BITS:0]          rd_diff;
   logic signed [PROD_BITS-1:0]          prod_rnd;
   logic signed [SUM_BITS-1:0]           y;
   logic signed [cmd_pkg::SAMPLE_BITS-1:0] y_sat, rsp_data_in;

   assign req_port.ready  = (state_ff == ST_IDLE);
   assign accept          = req_port.valid && req_port.ready;
   assign advance         = accept && !bypass_ff;
   assign out_free        = !rsp_valid_ff || rsp_port.ready;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.sample_out = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_delay_ff  <= '0;
         depth_gain_ff  <= 16'd24576;
         sweep_width_ff <= '0;
         lfo_step_ff    <= '0;
         wet_mix_ff     <= '0;
         rate_count_ff  <= 18'd48000;
         bypass_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            cmd_pkg::REG_BASE_DELAY:  base_delay_ff  <= csr_wdata[10:0];
            cmd_pkg::REG_DEPTH_GAIN:  depth_gain_ff  <= csr_wdata[15:0];
            cmd_pkg::REG_SWEEP_WIDTH: sweep_width_ff <= csr_wdata[15:0];
            cmd_pkg::REG_LFO_STEP:    lfo_step_ff    <= csr_wdata[cmd_pkg::PHASE_BITS-1:0];
            cmd_pkg::REG_WET_MIX:     wet_mix_ff     <= csr_wdata[15:0];
            cmd_pkg::REG_RATE_COUNT:  rate_count_ff  <= csr_wdata[cmd_pkg::TICK_BITS-1:0];
            cmd_pkg::REG_BYPASS:      bypass_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      write_pos_in = write_pos_ff;
      if (csr_we && csr_index == cmd_pkg::REG_BASE_DELAY) begin
         write_pos_in = '0;
      end else if (advance) begin
         if (write_pos_ff == cmd_pkg::ADDR_BITS'(cmd_pkg::DELAY_DEPTH - 1)) begin
            write_pos_in = '0;
         end else begin
            write_pos_in = write_pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = bypass_ff ? ST_MIX : ST_RATIO;
            end
         end
         ST_RATIO: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_MULT;
         ST_MULT:  state_in = ST_MIX;
         ST_MIX: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_MIX && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         write_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         write_pos_ff <= write_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Read offset: clamp to zero when the scaled delay is not positive, else to the depth minus one.
   always_comb begin
      off_full = bd_ff[BD_BITS-1:30];
      if (bd_ff <= 0) begin
         off = '0;
      end else if (32'(off_full) > 32'(cmd_pkg::DELAY_DEPTH - 1)) begin
         off = cmd_pkg::ADDR_BITS'(cmd_pkg::DELAY_DEPTH - 1);
      end else begin
         off = off_full[cmd_pkg::ADDR_BITS-1:0];
      end
      rd_diff = {1'b0, item_wp_ff} - {1'b0, off};
      if (item_wp_ff < off) begin
         rd_diff = rd_diff + (cmd_pkg::ADDR_BITS+1)'(cmd_pkg::DELAY_DEPTH);
      end
   end

   assign wr.en   = advance;
   assign wr.addr = write_pos_ff;
   assign wr.data = req_port.sample_in;
   assign rd.en   = (state_ff == ST_ADDR);
   assign rd.addr = rd_diff[cmd_pkg::ADDR_BITS-1:0];

   cmd_lfo u_lfo (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .lfo_step   (lfo_step_ff),
      .rate_count (rate_count_ff),
      .sine       (sine)
   );

   cmd_delay_line u_delay_line (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (fb)
   );

   // The arithmetic shift floors, which rounds ties toward positive infinity.
   always_comb begin
      prod_rnd = prod_ff + PROD_BITS'(signed'(64'sd536870912));
      y = SUM_BITS'(sample_ff) + SUM_BITS'(signed'(prod_rnd[PROD_BITS-1:30]));
      if (y > SUM_BITS'((64'sd1 <<< (cmd_pkg::SAMPLE_BITS - 1)) - 1)) begin
         y_sat = {1'b0, {(cmd_pkg::SAMPLE_BITS-1){1'b1}}};
      end else if (y < -SUM_BITS'(64'sd1 <<< (cmd_pkg::SAMPLE_BITS - 1))) begin
         y_sat = {1'b1, {(cmd_pkg::SAMPLE_BITS-1){1'b0}}};
      end else begin
         y_sat = y[cmd_pkg::SAMPLE_BITS-1:0];
      end
      rsp_data_in = item_bypass_ff ? sample_ff : y_sat;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff      <= req_port.sample_in;
         item_bypass_ff <= bypass_ff;
         item_wp_ff     <= write_pos_ff;
      end
      if (state_ff == ST_RATIO) begin
         ratio_ff <= RATIO_BITS'(signed'(64'sd1073741824))
                     + RATIO_BITS'(signed'({1'b0, sweep_width_ff}) * sine);
         gain_ff  <= GAIN_BITS'(wet_mix_ff * depth_gain_ff);
      end
      if (state_ff == ST_SCALE) begin
         bd_ff <= BD_BITS'(signed'({1'b0, base_delay_ff}) * ratio_ff);
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= PROD_BITS'(signed'({1'b0, gain_ff}) * fb);
      end
      if (state_ff == ST_MIX && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_load_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MIX))
      else $error("response loaded outside the mix step");

   a_mix_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) && rsp_valid_ff && !rsp_port.ready |=> state_ff == ST_MIX)
      else $error("mix step left while the response register was full");

   a_effect_path: assert property (@(posedge clock) disable iff (reset)
      accept && !bypass_ff |=> state_ff == ST_RATIO && item_wp_ff == $past(write_pos_ff))
      else $error("accepted word did not enter the effect path");

endmodule

FILE: verif/testbench.sv
// Testbench for chorus_modulated_delay: sends sample words, predicts each output word
// in a scoreboard class and compares them as they arrive.
// Depends on cmd_pkg and the cmd_req_if and cmd_rsp_if interfaces of the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cmd_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] word_t;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] base_delay;
      logic [CSR_DATA_BITS-1:0] depth_gain;
      logic [CSR_DATA_BITS-1:0] sweep_width;
      logic [CSR_DATA_BITS-1:0] lfo_step;
      logic [CSR_DATA_BITS-1:0] wet_mix;
      logic [CSR_DATA_BITS-1:0] rate_count;
      logic [CSR_DATA_BITS-1:0] bypass;
   } chorus_settings_t;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
   typedef enum {FLAVOR_MAX, FLAVOR_MIN, FLAVOR_RANDOM} settings_flavor_t;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
   localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
   localparam word_t WORD_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam word_t WORD_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 156;
   localparam int BYPASS_PHASE = 5;
   localparam int MAX_PRINTED = 40;

   class chorus_scoreboard;
      longint                  sine_quarter [QUARTER+1];
      logic [ADDR_BITS-1:0]    base_delay;
      logic [TABLE_BITS-1:0]   depth_gain;
      logic [TABLE_BITS-1:0]   sweep_width;
      logic [TABLE_BITS-1:0]   wet_mix;
      logic [PHASE_BITS-1:0]   lfo_step;
      logic [PHASE_BITS-1:0]   lfo_phase;
      logic [TICK_BITS-1:0]    rate_count;
      logic [TICK_BITS-1:0]    tick_count;
      logic                    bypass;
      word_t                   delay_line [DELAY_DEPTH];
      logic [ADDR_BITS-1:0]    write_pos;
      word_t                   expected_words [$];
      int                      errors;
      int                      checked;

      // The quarter-wave table is a Taylor series in Q2.30, rounded to Q1.15.
      function new();
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] term;
         longint      total;
         for (int k = 0; k <= QUARTER; k++) begin
            x = 64'(k) * QUARTER_TURN_Q30 / QUARTER;
            x2 = (x * x) >> 30;
            term = x;
            total = longint'(x);
            for (int n = 1; n <= 7; n++) begin
               term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  total -= longint'(term);
               end else begin
                  total += longint'(term);
               end
            end
            if (total < 0) begin
               total = 0;
            end
            total = (total + 16384) >>> 15;
            if (total > 32768) begin
               total = 32768;
            end
            sine_quarter[k] = total;
         end
         errors = 0;
         checked = 0;
         base_delay = '0;
         depth_gain = 16'd24576;
         sweep_width = '0;
         lfo_step = '0;
         wet_mix = '0;
         rate_count = 18'd48000;
         bypass = 1'b0;
         foreach (delay_line[i]) begin
            delay_line[i] = '0;
         end
         write_pos = '0;
         tick_count = '0;
         lfo_phase = '0;
      endfunction

      task report_mismatch(string msg);
         if (errors < MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
         errors++;
      endtask

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (index)
            REG_BASE_DELAY: begin
               base_delay = data[ADDR_BITS-1:0];
               write_pos = '0;
            end
            REG_DEPTH_GAIN: depth_gain = data[TABLE_BITS-1:0];
            REG_SWEEP_WIDTH: sweep_width = data[TABLE_BITS-1:0];
            REG_LFO_STEP: lfo_step = data[PHASE_BITS-1:0];
            REG_WET_MIX: wet_mix = data[TABLE_BITS-1:0];
            REG_RATE_COUNT: rate_count = data[TICK_BITS-1:0];
            REG_BYPASS: bypass = data[0];
            default: ;
         endcase
      endfunction

      function longint lfo_sine(logic [PHASE_BITS-1:0] phase);
         logic [SINE_IDX_BITS-1:0] step_idx;
         int                       r;
         step_idx = phase[PHASE_BITS-1 -: SINE_IDX_BITS];
         r = int'(step_idx[QUARTER_BITS-1:0]);
         case (step_idx[SINE_IDX_BITS-1 -: 2])
            2'd0: return sine_quarter[r];
            2'd1: return sine_quarter[QUARTER - r];
            2'd2: return -sine_quarter[r];
            default: return -sine_quarter[QUARTER - r];
         endcase
      endfunction

      // Computes the output word for an accepted input word and advances the state.
      function void note_word(word_t dry);
         longint ratio;
         longint scaled;
         longint offset;
         longint gain;
         longint delayed;
         longint mixed;
         int     read_pos;
         if (bypass) begin
            expected_words.push_back(dry);
            return;
         end
         delay_line[write_pos] = dry;
         ratio = (longint'(1) << 30) + longint'(sweep_width) * lfo_sine(lfo_phase);
         scaled = longint'(base_delay) * ratio;
         offset = (scaled <= 0) ? 0 : (scaled >>> 30);
         if (offset > DELAY_DEPTH - 1) begin
            offset = DELAY_DEPTH - 1;
         end
         read_pos = (int'(write_pos) - int'(offset) + DELAY_DEPTH) % DELAY_DEPTH;
         delayed = delay_line[read_pos];
         write_pos = write_pos + 1'b1;
         tick_count = tick_count + 1'b1;
         if (tick_count >= rate_count) begin
            tick_count = '0;
            lfo_phase = '0;
         end else begin
            lfo_phase = lfo_phase + lfo_step;
         end
         gain = longint'(wet_mix) * longint'(depth_gain);
         mixed = longint'(dry) + ((gain * delayed + (longint'(1) << 29)) >>> 30);
         if (mixed > longint'(WORD_MAX)) begin
            mixed = WORD_MAX;
         end
         if (mixed < longint'(WORD_MIN)) begin
            mixed = WORD_MIN;
         end
         expected_words.push_back(word_t'(mixed));
      endfunction

      task check_word(word_t got);
         word_t want;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("output word %0d with none expected", got));
         end else begin
            want = expected_words.pop_front();
            checked++;
            if (got !== want) begin
               report_mismatch($sformatf("sample_out %0d, expected %0d", got, want));
            end
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;
   int                         send_idle_pct;
   int                         recv_stall_pct;
   int                         settings_count;
   int                         cycle_count;
   chorus_scoreboard           board;

   cmd_req_if req_if ();
   cmd_rsp_if rsp_if ();

   chorus_modulated_delay DUT (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_if),
      .rsp_port  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         board.check_word(rsp_if.sample_out);
      end
   end

   function automatic logic [CSR_DATA_BITS-1:0] noisy(logic [CSR_DATA_BITS-1:0] value,
                                                      int bits);
      logic [CSR_DATA_BITS-1:0] keep;
      keep = (bits >= CSR_DATA_BITS) ? '1 : ((32'd1 << bits) - 1);
      return (value & keep) | ($urandom() & ~keep);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_gain();
      case ($urandom_range(4))
         0: return 0;
         1: return 32768;
         2: return 65535;
         3: return $urandom_range(32768);
         default: return $urandom_range(65535);
      endcase
   endfunction

   function automatic chorus_settings_t make_settings(int bd, int dg, int sw,
                                                      logic [31:0] st, int wm, int rc,
                                                      int bp);
      chorus_settings_t cfg;
      cfg.base_delay = bd;
      cfg.depth_gain = dg;
      cfg.sweep_width = sw;
      cfg.lfo_step = st;
      cfg.wet_mix = wm;
      cfg.rate_count = rc;
      cfg.bypass = bp;
      return cfg;
   endfunction

   function automatic chorus_settings_t random_settings(settings_flavor_t flavor);
      chorus_settings_t cfg;
      if (flavor == FLAVOR_MAX) begin
         return make_settings(DELAY_DEPTH - 1, 65535, 65535, '1, 65535,
                              (1 << TICK_BITS) - 1, 0);
      end
      if (flavor == FLAVOR_MIN) begin
         return make_settings(0, 0, 0, '0, 0, 0, 0);
      end
      case ($urandom_range(4))
         0: cfg.base_delay = DELAY_DEPTH - 1;
         1: cfg.base_delay = $urandom_range(1, 16);
         2: cfg.base_delay = $urandom_range(1, 150);
         default: cfg.base_delay = $urandom_range(DELAY_DEPTH - 1);
      endcase
      cfg.depth_gain = pick_gain();
      cfg.sweep_width = pick_gain();
      cfg.wet_mix = pick_gain();
      case ($urandom_range(3))
         0: cfg.lfo_step = $urandom_range(255) << 24;
         1: cfg.lfo_step = '1;
         default: cfg.lfo_step = $urandom();
      endcase
      case ($urandom_range(5))
         0: cfg.rate_count = 0;
         1: cfg.rate_count = 1;
         2: cfg.rate_count = (1 << TICK_BITS) - 1;
         3: cfg.rate_count = 48000;
         default: cfg.rate_count = $urandom_range(2, 300);
      endcase
      cfg.bypass = 0;
      return cfg;
   endfunction

   function automatic word_t random_word();
      case ($urandom_range(9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return word_t'(int'($urandom_range(511)) - 256);
         default: return word_t'($urandom());
      endcase
   endfunction

   task automatic set_idling(idle_mode_t mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 50;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 50;
         end
         default: begin
            send_idle_pct = 36;
            recv_stall_pct = 36;
         end
      endcase
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index,
                            logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      board.write_register(index, data);
      @(negedge clock);
   endtask

   // Leaving base_delay alone keeps the write pointer running across settings.
   task automatic program_settings(chorus_settings_t cfg, bit keep_pointer);
      if (!keep_pointer) begin
         write_csr(REG_BASE_DELAY, noisy(cfg.base_delay, ADDR_BITS));
      end
      write_csr(REG_DEPTH_GAIN, noisy(cfg.depth_gain, TABLE_BITS));
      write_csr(REG_SWEEP_WIDTH, noisy(cfg.sweep_width, TABLE_BITS));
      write_csr(REG_LFO_STEP, noisy(cfg.lfo_step, PHASE_BITS));
      write_csr(REG_WET_MIX, noisy(cfg.wet_mix, TABLE_BITS));
      write_csr(REG_RATE_COUNT, noisy(cfg.rate_count, TICK_BITS));
      write_csr(REG_UNUSED, $urandom());
      write_csr(REG_BYPASS, noisy(cfg.bypass, 1));
      csr_we <= 1'b0;
      @(negedge clock);
      settings_count++;
   endtask

   task automatic send_word(word_t word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample_in <= word;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.note_word(word);
      @(negedge clock);
   endtask

   task automatic wait_for_outputs();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (board.expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("chorus_modulated_delay verification failed");
      $finish;
   end

   initial begin
      int pause_at;
      chorus_settings_t cfg;
      settings_flavor_t flavor;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready = 1'b0;
      settings_count = 0;
      set_idling(IDLE_NONE);
      board = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults leave the wet path off, so the output follows the input.
      send_word(WORD_MAX);
      send_word(WORD_MIN);
      send_word('0);
      wait_for_outputs();

      // Short fixed delay with gains above unity drives saturation both ways.
      program_settings(make_settings(3, 65535, 0, '0, 65535, 0, 0), 1'b0);
      send_word(WORD_MAX);
      send_word(WORD_MAX);
      send_word(WORD_MIN);
      send_word(WORD_MIN);
      send_word(word_t'(-1));
      send_word(word_t'(1));
      send_word(WORD_MAX);
      send_word(WORD_MIN);
      wait_for_outputs();

      // A wide sweep walks all four quadrants, clamping the offset high and at zero.
      program_settings(make_settings(DELAY_DEPTH - 1, 32768, 65535, 32'h4100_0000,
                                     32768, 5, 0), 1'b0);
      for (int i = 0; i < 8; i++) begin
         send_word(random_word());
      end
      wait_for_outputs();

      program_settings(make_settings(7, 65535, 65535, '1, 65535, 1, 1), 1'b0);
      send_word(WORD_MAX);
      send_word(WORD_MIN);
      send_word(random_word());
      wait_for_outputs();

      for (int p = 0; p < PHASES; p++) begin
         set_idling(idle_mode_t'(p % 4));
         flavor = (p == 0) ? FLAVOR_MAX : (p == 1) ? FLAVOR_MIN : FLAVOR_RANDOM;
         cfg = random_settings(flavor);
         if (p == BYPASS_PHASE) begin
            cfg.bypass = 1;
         end
         program_settings(cfg, p % 3 == 2);
         pause_at = $urandom_range(20, WORDS_PER_PHASE - 20);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (i == pause_at) begin
               wait_for_outputs();
            end
            send_word(random_word());
         end
         wait_for_outputs();
      end

      if (board.expected_words.size() != 0) begin
         board.report_mismatch($sformatf("%0d output words never arrived",
                                         board.expected_words.size()));
      end
      $display("Checked %0d output words under %0d register settings, %0d mismatches.",
               board.checked, settings_count, board.errors);
      $display("Covered saturation, clamped offsets, LFO wraps, bypass and idle mixes.");
      if (board.errors == 0) begin
         $display("chorus_modulated_delay verification clean");
      end else begin
         $display("chorus_modulated_delay verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/cmd_pkg.sv
sv/cmd_if.sv
sv/cmd_lfo.sv
sv/cmd_delay_line.sv
sv/chorus_modulated_delay.sv
verif/testbench.sv
